// ===== hdl/lkc_pkg.sv =====
// shared constants, codes and types of the lru key cache
`default_nettype none
package lkc_pkg;

	localparam int ENTRIES   = 16;
	localparam int KEY_BITS  = 32;
	localparam int SLOT_W    = $clog2(ENTRIES);
	localparam int RANK_W    = SLOT_W;
	localparam int OCC_W     = $clog2(ENTRIES + 1);
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CW        = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int MODE_W    = 2;
	localparam int KIND_W    = 3;
	localparam int OP_W      = 3;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_EVICT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HIT    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MISS   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BYPASS = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REMOVE   = 1'd1;

	localparam logic [CFG_W-1:0] CAP_RESET    = 5'd16;
	localparam logic [CFG_W-1:0] REMOVE_RESET = 5'd1;

	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_TOUCH  = 3'd2;
	localparam logic [OP_W-1:0] OP_EVICT  = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
	} rank_cmd_t;

	typedef struct packed {
		logic [ENTRIES-1:0] valid;
		logic [OCC_W-1:0]   occ;
		logic [SLOT_W-1:0]  victim;
		logic [SLOT_W-1:0]  free_slot;
	} rank_stat_t;

endpackage
`default_nettype wire

// ===== hdl/lkc_if.sv =====
// request and response channel interfaces of the lru key cache
`default_nettype none
interface lkc_req_if;
	import lkc_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [KEY_BITS-1:0] key;
	modport source (output valid, output mode, output key, input ready);
	modport sink (input valid, input mode, input key, output ready);
endinterface

interface lkc_rsp_if;
	import lkc_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [KEY_BITS-1:0] result_key;
	logic [SLOT_W-1:0]   slot;
	logic                last;
	modport source (output valid, output kind, output result_key, output slot, output last,
		input ready);
	modport sink (input valid, input kind, input result_key, input slot, input last,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/lru_key_cache_batch_evict_core.sv =====
// Fully associative key cache with least-recently-used replacement and batch
// eviction. One request transaction is taken at a time; req.ready is high only
// while the sequencer is idle. A lookup walks the key ram one slot per cycle
// through a single shared comparator (registered ram read, one compare stage).
// A hit answers as soon as the compare of its slot matches. A miss scans every
// slot; when occupancy has reached capacity, evicted keys come out oldest
// first, then the insert. Bypass and clear go straight to the emit state, and
// mode 3 is absorbed with no response. The sequencer is idle again at the edge
// that loads the final response. The response sits in an output register, so
// a new request is taken while the last response still waits; a stalled
// response stalls the sequencer. The user must write capacity and remove count
// only while idle; the block itself does not enforce it.
`default_nettype none
module lru_key_cache_batch_evict_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	lkc_req_if.sink                                req,
	lkc_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [lkc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lkc_pkg::CFG_W-1:0]         cfg_data
);
	import lkc_pkg::*;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
	localparam logic [ST_W-1:0] ST_SCAN   = 3'd1;
	localparam logic [ST_W-1:0] ST_EVSEL  = 3'd2;
	localparam logic [ST_W-1:0] ST_EVRD   = 3'd3;
	localparam logic [ST_W-1:0] ST_INSERT = 3'd4;
	localparam logic [ST_W-1:0] ST_EMIT   = 3'd5;

	logic [ST_W-1:0]     state_q;
	logic [CFG_W-1:0]    capacity_q;
	logic [CFG_W-1:0]    remove_q;
	logic [KEY_BITS-1:0] key_q;
	logic [OCC_W-1:0]    scan_q;
	logic                look_s1;
	logic [SLOT_W-1:0]   look_slot_s1;
	logic [OCC_W-1:0]    evict_cnt_q;
	logic [SLOT_W-1:0]   victim_q;
	logic [KIND_W-1:0]   pend_kind_q;
	logic [SLOT_W-1:0]   pend_slot_q;

	logic                rsp_valid_q;
	logic [KIND_W-1:0]   rsp_kind_q;
	logic [KEY_BITS-1:0] rsp_key_q;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic                rsp_last_q;

	rank_cmd_t           rcmd;
	rank_stat_t          rstat;
	logic [SLOT_W-1:0]   ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;
	logic                ram_we;

	logic                req_take;
	logic                out_free;
	logic                rsp_load;
	logic                hit_now;
	logic                scan_end;
	logic                full;
	logic [CW-1:0]       occ_ext;
	logic [CW-1:0]       cap_eff;
	logic [CW-1:0]       cnt_eff;

	lkc_rank u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.stat   (rstat)
	);

	lkc_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rstat.free_slot),
		.wdata (key_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready  = (state_q == ST_IDLE);
	assign req_take   = req.valid && (state_q == ST_IDLE);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign rsp_load   = ((state_q == ST_EVRD) || (state_q == ST_EMIT)) && out_free;
	assign hit_now    = look_s1 && rstat.valid[look_slot_s1] && (ram_rdata == key_q);
	assign scan_end   = look_s1 && (look_slot_s1 == SLOT_W'(ENTRIES - 1));
	assign ram_we     = (state_q == ST_INSERT);

	// capacity and remove count clamped, count also clamped to occupancy
	always_comb begin
		occ_ext = CW'(rstat.occ);
		cap_eff = CW'(capacity_q);
		if (cap_eff == '0) begin
			cap_eff = CW'(1);
		end else if (cap_eff > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end
		cnt_eff = CW'(remove_q);
		if (cnt_eff == '0) begin
			cnt_eff = CW'(1);
		end
		if (cnt_eff > occ_ext) begin
			cnt_eff = occ_ext;
		end
		full = (occ_ext >= cap_eff);
	end

	always_comb begin
		priority if (state_q == ST_EVSEL) begin
			ram_raddr = rstat.victim;
		end else if (state_q == ST_EVRD) begin
			ram_raddr = victim_q;
		end else begin
			ram_raddr = scan_q[SLOT_W-1:0];
		end
	end

	always_comb begin
		rcmd.op   = OP_NONE;
		rcmd.slot = look_slot_s1;
		if (req_take && (req.mode == MODE_CLEAR)) begin
			rcmd.op = OP_CLEAR;
		end else if ((state_q == ST_SCAN) && hit_now) begin
			rcmd.op = OP_TOUCH;
		end else if (state_q == ST_EVSEL) begin
			rcmd.op = OP_EVICT;
		end else if (state_q == ST_INSERT) begin
			rcmd.op = OP_INSERT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= CAP_RESET;
			remove_q    <= REMOVE_RESET;
			scan_q      <= '0;
			look_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CAPACITY: capacity_q <= cfg_data;
					REG_REMOVE:   remove_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					scan_q  <= '0;
					look_s1 <= 1'b0;
					if (req_take) begin
						unique case (req.mode)
							MODE_LOOKUP: state_q <= ST_SCAN;
							MODE_BYPASS: state_q <= ST_EMIT;
							MODE_CLEAR:  state_q <= ST_EMIT;
							default:     state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					look_s1 <= (scan_q < OCC_W'(ENTRIES));
					if (scan_q < OCC_W'(ENTRIES)) begin
						scan_q <= scan_q + OCC_W'(1);
					end
					if (hit_now) begin
						state_q <= ST_EMIT;
					end else if (scan_end) begin
						state_q <= full ? ST_EVSEL : ST_INSERT;
					end
				end
				ST_EVSEL: begin
					state_q <= ST_EVRD;
				end
				ST_EVRD: begin
					if (out_free) begin
						state_q <= (evict_cnt_q == OCC_W'(1)) ? ST_INSERT : ST_EVSEL;
					end
				end
				ST_INSERT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					key_q       <= req.key;
					pend_kind_q <= (req.mode == MODE_CLEAR) ? KIND_CLEAR : KIND_BYPASS;
					pend_slot_q <= '0;
				end
			end
			ST_SCAN: begin
				look_slot_s1 <= scan_q[SLOT_W-1:0];
				if (hit_now) begin
					pend_kind_q <= KIND_HIT;
					pend_slot_q <= look_slot_s1;
				end else if (scan_end) begin
					evict_cnt_q <= OCC_W'(cnt_eff);
				end
			end
			ST_EVSEL: begin
				victim_q <= rstat.victim;
			end
			ST_EVRD: begin
				if (out_free) begin
					rsp_kind_q  <= KIND_EVICT;
					rsp_key_q   <= ram_rdata;
					rsp_slot_q  <= victim_q;
					rsp_last_q  <= 1'b0;
					evict_cnt_q <= evict_cnt_q - OCC_W'(1);
				end
			end
			ST_INSERT: begin
				pend_kind_q <= KIND_MISS;
				pend_slot_q <= rstat.free_slot;
			end
			ST_EMIT: begin
				if (out_free) begin
					rsp_kind_q <= pend_kind_q;
					rsp_key_q  <= key_q;
					rsp_slot_q <= pend_slot_q;
					rsp_last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.kind       = rsp_kind_q;
	assign rsp.result_key = rsp_key_q;
	assign rsp.slot       = rsp_slot_q;
	assign rsp.last       = rsp_last_q;
endmodule
`default_nettype wire

// ===== hdl/lkc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module lkc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/lkc_rank.sv =====
// valid bits, exact recency ranks and occupancy of the cache entries
`default_nettype none
module lkc_rank (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lkc_pkg::rank_cmd_t cmd,
	output lkc_pkg::rank_stat_t     stat
);
	import lkc_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0]  rank_q [ENTRIES];
	logic [OCC_W-1:0]   occ_q;
	logic [RANK_W-1:0]  oldest;
	logic [RANK_W-1:0]  touch_rank;
	logic [SLOT_W-1:0]  victim;
	logic [SLOT_W-1:0]  free_slot;

	// lowest index wins for both searches
	always_comb begin
		oldest     = RANK_W'(occ_q - OCC_W'(1));
		touch_rank = rank_q[cmd.slot];
		victim     = '0;
		free_slot  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (rank_q[i] == oldest)) begin
				victim = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			unique case (cmd.op)
				OP_CLEAR: begin
					valid_q <= '0;
					occ_q   <= '0;
					for (int i = 0; i < ENTRIES; i++) begin
						rank_q[i] <= '0;
					end
				end
				OP_TOUCH: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && (rank_q[i] < touch_rank)) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end
					rank_q[cmd.slot] <= '0;
				end
				OP_EVICT: begin
					valid_q[victim] <= 1'b0;
					rank_q[victim]  <= '0;
					occ_q           <= occ_q - OCC_W'(1);
				end
				OP_INSERT: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end
					rank_q[free_slot]  <= '0;
					valid_q[free_slot] <= 1'b1;
					occ_q              <= occ_q + OCC_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.valid     = valid_q;
	assign stat.occ       = occ_q;
	assign stat.victim    = victim;
	assign stat.free_slot = free_slot;
endmodule
`default_nettype wire

// ===== hdl/lkc_checker.sv =====
// port-level checks of the lru key cache and their binding to the top level
`default_nettype none
module lkc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic [lkc_pkg::MODE_W-1:0]    req_mode,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [lkc_pkg::KIND_W-1:0]    rsp_kind,
	input wire logic [lkc_pkg::SLOT_W-1:0]    rsp_slot,
	input wire logic                          rsp_last
);
	import lkc_pkg::*;

	// a pending response is not withdrawn
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// only evictions are non-final, and no request is taken during a burst
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> (rsp_kind == KIND_EVICT) && !req_ready)
		else $error("non-final response is not an eviction inside a burst");

	// a request that produces responses keeps the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_mode != MODE_NONE) |=> !req_ready)
		else $error("request taken back to back with a working request");

	// bypass and clear report slot zero
	a_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_kind == KIND_BYPASS) || (rsp_kind == KIND_CLEAR))
		|-> (rsp_slot == '0) && rsp_last)
		else $error("bypass or clear response with nonzero slot or not final");
endmodule

bind lru_key_cache_batch_evict_core lkc_checker u_lkc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_mode  (req.mode),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.kind),
	.rsp_slot  (rsp.slot),
	.rsp_last  (rsp.last)
);
`default_nettype wire

// ===== test/lru_key_cache_batch_evict_core_test.sv =====
// self-checking testbench of the lru key cache with batch eviction
`timescale 1ns / 1ps
module lru_key_cache_batch_evict_core_test;
	import lkc_pkg::*;

	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_PRINTED    = 40;

	typedef struct {
		logic [MODE_W-1:0]   mode;
		logic [KEY_BITS-1:0] key;
	} cache_req_t;

	typedef struct {
		logic [KIND_W-1:0]   kind;
		logic [KEY_BITS-1:0] rkey;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} cache_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	lkc_req_if req();
	lkc_rsp_if rsp();

	lru_key_cache_batch_evict_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	cache_req_t          pending_requests[$];
	cache_result_t       expected_results[$];
	logic [KEY_BITS-1:0] key_pool[$];
	cache_req_t          next_request;

	// shadow copy of the cache contents
	bit                  line_valid[ENTRIES];
	logic [KEY_BITS-1:0] line_key[ENTRIES];
	int unsigned         line_age[ENTRIES];
	int unsigned         fill_count;
	logic [CFG_W-1:0]    capacity_reg;
	logic [CFG_W-1:0]    remove_reg;

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int quiet_cycles;
	int hold_requests;
	int hold_served;
	int hold_left;

	function automatic void push_result(input logic [KIND_W-1:0] kind,
		input logic [KEY_BITS-1:0] rkey, input int slot, input logic last);
		cache_result_t r;
		r.kind = kind;
		r.rkey = rkey;
		r.slot = SLOT_W'(slot);
		r.last = last;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void queue_request(input logic [MODE_W-1:0] mode,
		input logic [KEY_BITS-1:0] key);
		cache_req_t r;
		r.mode = mode;
		r.key = key;
		pending_requests.insert(pending_requests.size(), r);
	endfunction

	function automatic void predict_results(input logic [MODE_W-1:0] mode,
		input logic [KEY_BITS-1:0] key);
		int          hit_slot;
		int unsigned cap_limit;
		int unsigned evict_count;
		int unsigned age;
		hit_slot = -1;
		if (mode == MODE_BYPASS) begin
			push_result(KIND_BYPASS, key, 0, 1'b1);
			return;
		end
		if (mode == MODE_CLEAR) begin
			for (int i = 0; i < ENTRIES; i++) begin
				line_valid[i] = 1'b0;
				line_age[i] = 0;
			end
			fill_count = 0;
			push_result(KIND_CLEAR, key, 0, 1'b1);
			return;
		end
		if (mode != MODE_LOOKUP)
			return;
		for (int i = 0; i < ENTRIES; i++)
			if (hit_slot < 0 && line_valid[i] && line_key[i] == key)
				hit_slot = i;
		if (hit_slot >= 0) begin
			age = line_age[hit_slot];
			for (int j = 0; j < ENTRIES; j++)
				if (line_valid[j] && line_age[j] < age)
					line_age[j]++;
			line_age[hit_slot] = 0;
			push_result(KIND_HIT, key, hit_slot, 1'b1);
			return;
		end
		cap_limit = capacity_reg;
		if (cap_limit < 1)
			cap_limit = 1;
		if (cap_limit > ENTRIES)
			cap_limit = ENTRIES;
		if (fill_count >= cap_limit) begin
			evict_count = remove_reg;
			if (evict_count < 1)
				evict_count = 1;
			if (evict_count > fill_count)
				evict_count = fill_count;
			// oldest first: the oldest line always has age fill_count - 1
			for (int e = 0; e < evict_count; e++) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (line_valid[i] && line_age[i] == fill_count - 1) begin
						line_valid[i] = 1'b0;
						line_age[i] = 0;
						fill_count--;
						push_result(KIND_EVICT, line_key[i], i, 1'b0);
						break;
					end
				end
			end
		end
		for (int i = 0; i < ENTRIES; i++)
			if (line_valid[i])
				line_age[i]++;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!line_valid[i]) begin
				line_valid[i] = 1'b1;
				line_key[i] = key;
				line_age[i] = 0;
				fill_count++;
				push_result(KIND_MISS, key, i, 1'b1);
				return;
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_result();
		cache_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d key %h slot %0d",
				rsp.kind, rsp.result_key, rsp.slot));
			return;
		end
		want = expected_results.pop_front();
		if (rsp.kind !== want.kind)
			report_mismatch($sformatf("kind %0d, expected %0d", rsp.kind, want.kind));
		if (rsp.result_key !== want.rkey)
			report_mismatch($sformatf("result_key %h, expected %h", rsp.result_key,
				want.rkey));
		if (rsp.slot !== want.slot)
			report_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
		if (rsp.last !== want.last)
			report_mismatch($sformatf("last %0d, expected %0d", rsp.last, want.last));
	endtask

	// request driver, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= MODE_LOOKUP;
			req.key <= '0;
		end else begin
			if (req.valid && req.ready)
				predict_results(req.mode, req.key);
			if (!req.valid || req.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_request = pending_requests.pop_front();
					req.valid <= 1'b1;
					req.mode <= next_request.mode;
					req.key <= next_request.key;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off, started on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_served <= 0;
			hold_left <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_CAPACITY)
			capacity_reg = val;
		else
			remove_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sample at the falling edge so driver pops and updates have settled
	task automatic drain();
		while (pending_requests.size() != 0 || req.valid || expected_results.size() != 0)
			@(negedge clk);
		// an unused-mode transaction gives no response but may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic cache_req_t random_request();
		cache_req_t  r;
		int unsigned pick;
		pick = $urandom_range(99);
		r.mode = MODE_LOOKUP;
		r.key = key_pool[$urandom_range(key_pool.size() - 1)];
		if (pick >= 82 && pick < 88)
			r.key = $urandom();
		else if (pick >= 88 && pick < 93)
			r.mode = MODE_BYPASS;
		else if (pick >= 93 && pick < 95)
			r.mode = MODE_CLEAR;
		else if (pick >= 95)
			r.mode = MODE_NONE;
		return r;
	endfunction

	task automatic run_phase(input int cap, input int rmv, input int idle_pct,
		input int stall_pct, input int pool_size, input int count, input bit hold_off);
		cache_req_t r;
		int         n;
		write_reg(REG_CAPACITY, CFG_W'(cap));
		write_reg(REG_REMOVE, CFG_W'(rmv));
		@(negedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		key_pool.delete();
		repeat (pool_size) key_pool.insert(key_pool.size(), $urandom());
		if (hold_off)
			hold_requests++;
		n = 0;
		// unused-mode transactions are extra, they do not count
		while (n < count) begin
			r = random_request();
			pending_requests.insert(pending_requests.size(), r);
			if (r.mode != MODE_NONE)
				n++;
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = MODE_LOOKUP;
		req.key = '0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CAPACITY;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		quiet_cycles = 0;
		hold_requests = 0;
		capacity_reg = CAP_RESET;
		remove_reg = REMOVE_RESET;
		fill_count = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			line_valid[i] = 1'b0;
			line_key[i] = '0;
			line_age[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset settings
		queue_request(MODE_BYPASS, 32'h0000_0000);
		queue_request(MODE_BYPASS, 32'hFFFF_FFFF);
		queue_request(MODE_NONE, 32'h1234_5678);
		queue_request(MODE_CLEAR, 32'hA5A5_A5A5);
		queue_request(MODE_LOOKUP, 32'h0000_0000);
		queue_request(MODE_LOOKUP, 32'hFFFF_FFFF);
		queue_request(MODE_LOOKUP, 32'h0000_0000);
		for (int k = 1; k <= 14; k++)
			queue_request(MODE_LOOKUP, KEY_BITS'(32'h1111_1111 * k));
		// full cache: each miss evicts the oldest line
		queue_request(MODE_LOOKUP, 32'hDEAD_BEEF);
		queue_request(MODE_LOOKUP, 32'hFFFF_FFFF);
		queue_request(MODE_CLEAR, 32'h5A5A_5A5A);
		drain();

		run_phase(4, 3, 53, 0, 7, 30, 1'b0);
		run_phase(1, 9, 0, 53, 3, 25, 1'b0);
		// zero settings act as one
		run_phase(0, 0, 11, 11, 3, 25, 1'b0);
		run_phase(16, 16, 0, 0, 20, 35, 1'b0);
		// receiver holds off while the sender keeps offering
		run_phase(31, 31, 0, 53, 22, 35, 1'b1);
		// capacity dropped below the current fill
		run_phase(3, 2, 53, 0, 6, 30, 1'b0);
		run_phase(8, 5, 11, 11, 12, 40, 1'b0);
		run_phase(12, 2, 0, 0, 15, 30, 1'b0);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== lru_key_cache_batch_evict_core.f =====
hdl/lkc_pkg.sv
hdl/lkc_if.sv
hdl/lkc_ram.sv
hdl/lkc_rank.sv
hdl/lru_key_cache_batch_evict_core.sv
hdl/lkc_checker.sv
test/lru_key_cache_batch_evict_core_test.sv
